// ===== rtl/core/rgbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbm_pkg: shared types and constants of the mono bit packer
// Luma weights, reciprocal for the divide by 1000, field widths, register
// indexes and the row width limit.
// ----------------------------------------------------------------------------
package rgbm_pkg;

    localparam int PIX_W         = 8;
    localparam int BYTE_W        = 8;
    localparam int THRESH_W      = 8;
    localparam int ROW_WIDTH_W   = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 2;

    localparam int MAX_ROW_WIDTH = 4096;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int NEXT_W        = COL_W + 1;
    localparam int CMP_W         = (NEXT_W > ROW_WIDTH_W) ? NEXT_W : ROW_WIDTH_W;
    localparam int BIT_IDX_W     = $clog2(BYTE_W);

    // Weighted channel sum, at most 1000 * 255
    localparam int SUM_W         = 18;
    localparam logic [SUM_W-1:0] LUMA_R_K = SUM_W'(299);
    localparam logic [SUM_W-1:0] LUMA_G_K = SUM_W'(587);
    localparam logic [SUM_W-1:0] LUMA_B_K = SUM_W'(114);

    // floor(s / 1000) == (s * ceil(2^28 / 1000)) >> 28 for every s below 2^18
    localparam int RECIP_SHIFT   = 28;
    localparam int RECIP_W       = 19;
    localparam logic [RECIP_W-1:0] RECIP_1000 =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000);
    localparam int PROD_W        = SUM_W + RECIP_W;

    // Blend over white, compared against 255 * threshold
    localparam int BLEND_W       = 17;
    localparam logic [PIX_W-1:0] ALPHA_FULL = PIX_W'(255);
    localparam logic [BYTE_W-1:0] MSB_MASK  = BYTE_W'(8'h80);

    localparam logic [THRESH_W-1:0]    THRESH_RESET    = THRESH_W'(128);
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(384);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_ROW_WIDTH = 2'd1
    } t_cfg_idx;

endpackage

// ===== rtl/core/rgbm_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbm_pix_if: pixel stream channel
// One BGRA pixel per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgbm_pix_if import rgbm_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] alpha;

    modport source (output valid, output blue, output green, output red,
                    output alpha, input ready);
    modport sink   (input valid, input blue, input green, input red,
                    input alpha, output ready);

endinterface

// ===== rtl/core/rgbm_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbm_byte_if: packed byte channel
// One byte of eight mono pixels per transaction, with a row end flag.
// ----------------------------------------------------------------------------
interface rgbm_byte_if import rgbm_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_byte;
    logic              row_end;

    modport source (output valid, output packed_byte, output row_end, input ready);
    modport sink   (input valid, input packed_byte, input row_end, output ready);

endinterface

// ===== rtl/core/rgbm_luma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbm_luma: luma and alpha blend threshold pipeline
// Four registered stages: input, weighted sum, divide by 1000, blend and
// compare. Each stage moves forward when its successor is free.
// ----------------------------------------------------------------------------
module rgbm_luma import rgbm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rgbm_pix_if.sink            i_pix,
    input  logic [THRESH_W-1:0] i_threshold,
    output logic                o_bit_valid,
    input  logic                i_bit_ready,
    output logic                o_bit_black
);

    logic r_v0, r_v1, r_v2, r_v3;
    logic s0_rdy, s1_rdy, s2_rdy, s3_rdy;

    logic [PIX_W-1:0] r_s0_blue, r_s0_green, r_s0_red, r_s0_alpha;
    logic [SUM_W-1:0] r_s1_sum;
    logic [PIX_W-1:0] r_s1_alpha;
    logic [PIX_W-1:0] r_s2_gray;
    logic [PIX_W-1:0] r_s2_alpha;
    logic             r_s3_black;

    logic [SUM_W-1:0]   n_sum;
    logic [PROD_W-1:0]  gray_prod;
    logic [PIX_W-1:0]   n_gray;
    logic [BLEND_W-1:0] blend_val;
    logic [BLEND_W-1:0] thresh_scaled;
    logic               n_black;

    assign s3_rdy = !r_v3 || i_bit_ready;
    assign s2_rdy = !r_v2 || s3_rdy;
    assign s1_rdy = !r_v1 || s2_rdy;
    assign s0_rdy = !r_v0 || s1_rdy;

    assign i_pix.ready = s0_rdy;
    assign o_bit_valid = r_v3;
    assign o_bit_black = r_s3_black;

    always_comb begin
        n_sum = LUMA_R_K * SUM_W'(r_s0_red) + LUMA_G_K * SUM_W'(r_s0_green)
              + LUMA_B_K * SUM_W'(r_s0_blue);
    end

    always_comb begin
        gray_prod = PROD_W'(r_s1_sum) * PROD_W'(RECIP_1000);
        n_gray    = gray_prod[RECIP_SHIFT +: PIX_W];
    end

    // blended < t  <=>  gray*a + 255*(255-a) < 255*t
    always_comb begin
        blend_val     = BLEND_W'(r_s2_gray) * BLEND_W'(r_s2_alpha)
                      + BLEND_W'(ALPHA_FULL) * BLEND_W'(ALPHA_FULL - r_s2_alpha);
        thresh_scaled = BLEND_W'(ALPHA_FULL) * BLEND_W'(i_threshold);
        n_black       = blend_val < thresh_scaled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s0_rdy) r_v0 <= i_pix.valid;
            if (s1_rdy) r_v1 <= r_v0;
            if (s2_rdy) r_v2 <= r_v1;
            if (s3_rdy) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_rdy) begin
            r_s0_blue  <= i_pix.blue;
            r_s0_green <= i_pix.green;
            r_s0_red   <= i_pix.red;
            r_s0_alpha <= i_pix.alpha;
        end
        if (s1_rdy) begin
            r_s1_sum   <= n_sum;
            r_s1_alpha <= r_s0_alpha;
        end
        if (s2_rdy) begin
            r_s2_gray  <= n_gray;
            r_s2_alpha <= r_s1_alpha;
        end
        if (s3_rdy) begin
            r_s3_black <= n_black;
        end
    end

endmodule

// ===== rtl/core/rgbm_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbm_packer: mono bit packer and output register
// Packs pixel bits MSB first, emits a byte every eight pixels and a padded
// byte with row end at the last pixel of each row.
// ----------------------------------------------------------------------------
module rgbm_packer import rgbm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_bit_valid,
    output logic                   o_bit_ready,
    input  logic                   i_bit_black,
    input  logic [ROW_WIDTH_W-1:0] i_row_width,
    rgbm_byte_if.source            o_byte
);

    logic [COL_W-1:0]  r_col, n_col;
    logic [BYTE_W-1:0] r_acc, n_acc;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_row_end, n_out_row_end;

    logic              out_free;
    logic              advance;
    logic [CMP_W-1:0]  width_eff;
    logic [NEXT_W-1:0] next_col;
    logic [BYTE_W-1:0] acc_set;
    logic              row_done;
    logic              byte_done;

    assign out_free    = !r_out_valid || o_byte.ready;
    assign advance     = i_bit_valid && out_free;
    assign o_bit_ready = out_free;

    assign o_byte.valid       = r_out_valid;
    assign o_byte.packed_byte = r_out_byte;
    assign o_byte.row_end     = r_out_row_end;

    // Zero width acts as one, wide rows saturate
    always_comb begin
        if (i_row_width == '0) begin
            width_eff = CMP_W'(1);
        end else if (CMP_W'(i_row_width) > CMP_W'(MAX_ROW_WIDTH)) begin
            width_eff = CMP_W'(MAX_ROW_WIDTH);
        end else begin
            width_eff = CMP_W'(i_row_width);
        end
    end

    always_comb begin
        next_col  = NEXT_W'(r_col) + NEXT_W'(1);
        acc_set   = r_acc | (i_bit_black ? (MSB_MASK >> r_col[BIT_IDX_W-1:0]) : '0);
        row_done  = CMP_W'(next_col) >= width_eff;
        byte_done = next_col[BIT_IDX_W-1:0] == '0;
    end

    always_comb begin
        n_col         = r_col;
        n_acc         = r_acc;
        n_out_valid   = r_out_valid && !o_byte.ready;
        n_out_byte    = r_out_byte;
        n_out_row_end = r_out_row_end;
        if (advance) begin
            if (row_done) begin
                n_out_valid   = 1'b1;
                n_out_byte    = acc_set;
                n_out_row_end = 1'b1;
                n_acc         = '0;
                n_col         = '0;
            end else if (byte_done) begin
                n_out_valid   = 1'b1;
                n_out_byte    = acc_set;
                n_out_row_end = 1'b0;
                n_acc         = '0;
                n_col         = next_col[COL_W-1:0];
            end else begin
                n_acc         = acc_set;
                n_col         = next_col[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte    <= n_out_byte;
        r_out_row_end <= n_out_row_end;
    end

endmodule

// ===== rtl/core/rgba_to_mono_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_to_mono_bit_packer: BGRA pixels to packed 1 bpp mono bytes
// i_pix carries one BGRA pixel per transaction in raster order; o_byte
// carries one packed byte per transaction, MSB leftmost, 1 = black, with
// row_end on the last (zero padded) byte of each row.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0 = threshold, 1 = row width); write only while the block is idle.
// Throughput: one pixel per clock; i_pix.ready stays high while o_byte
// is taken. A byte reaches o_byte after the pixel that completes it is
// accepted, passing the input register, three luma stages, then the
// output register.
// The divide by 1000 sits in its own stage as a 18x19 reciprocal multiply.
// When o_byte stalls, the output register holds and the stages behind it
// keep filling until all are full, then i_pix.ready drops.
// Reset (synchronous, active low) empties the pipeline, clears the column
// count and bit accumulator, and loads threshold 128 and row width 384.
// ----------------------------------------------------------------------------
module rgba_to_mono_bit_packer import rgbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rgbm_pix_if.sink              i_pix,
    rgbm_byte_if.source           o_byte,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [THRESH_W-1:0]    r_threshold;
    logic [ROW_WIDTH_W-1:0] r_row_width;

    logic bit_valid;
    logic bit_ready;
    logic bit_black;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_row_width <= ROW_WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[THRESH_W-1:0];
                CFG_ROW_WIDTH: r_row_width <= i_cfg_wdata[ROW_WIDTH_W-1:0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    rgbm_luma u_luma (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_threshold (r_threshold),
        .o_bit_valid (bit_valid),
        .i_bit_ready (bit_ready),
        .o_bit_black (bit_black)
    );

    rgbm_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bit_valid (bit_valid),
        .o_bit_ready (bit_ready),
        .i_bit_black (bit_black),
        .i_row_width (r_row_width),
        .o_byte      (o_byte)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_byte.valid)
        else $error("output valid right after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_byte.valid |-> i_pix.ready)
        else $error("pixel input stalled with an empty output");

    a_thresh_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == CFG_THRESHOLD
        |=> r_threshold == $past(i_cfg_wdata[THRESH_W-1:0]))
        else $error("threshold write lost");

endmodule
